// ----- hdl/bblc_pkg.sv -----
`default_nettype none
package bblc_pkg;

    localparam int ENTRIES_DEF     = 64;
    localparam int HANDLE_BITS_DEF = 32;
    localparam int MAXB_W          = 22;
    localparam logic [MAXB_W-1:0] MAX_BYTES_RST = 22'd1048576;

    typedef enum logic [2:0] {
        REQ_PUT      = 3'd0,
        REQ_GET      = 3'd1,
        REQ_REMOVE   = 3'd2,
        REQ_EXISTS   = 3'd3,
        REQ_TRIM     = 3'd4,
        REQ_CLR_ALL  = 3'd5,
        REQ_CLR_SRC  = 3'd6,
        REQ_SIZE_SRC = 3'd7
    } t_req;

    // Rank adjustment applied by the scan unit to every valid entry it visits.
    typedef enum logic [1:0] {
        ADJ_NONE      = 2'd0,
        ADJ_DEC_ABOVE = 2'd1,
        ADJ_INC_BELOW = 2'd2,
        ADJ_INC_ALL   = 2'd3
    } t_adj;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_LAST   = 5'b00100,
        S_DECIDE = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    typedef enum logic [2:0] {
        STG_A     = 3'b001,
        STG_DROP  = 3'b010,
        STG_FINAL = 3'b100
    } t_stage;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [63:0] key;
        logic [31:0] value_handle;
        logic [15:0] value_size;
        logic [1:0]  source_code;
        logic [6:0]  entry_limit;
    } t_in_word;

    typedef struct packed {
        logic        found;
        logic [31:0] out_value_handle;
        logic [1:0]  out_source;
        logic [21:0] byte_total;
        logic [6:0]  entry_count;
        logic [6:0]  evicted_now;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
        logic [31:0] eviction_count;
    } t_out_word;

    // Control for one pass of the scan unit.
    typedef struct packed {
        t_adj        adj;
        logic        set_en;
        logic [63:0] key;
        logic [31:0] handle;
        logic [15:0] size;
        logic [1:0]  src;
    } t_pass_ctl;

endpackage
`default_nettype wire

// ----- hdl/bblc_ram.sv -----
`default_nettype none
module bblc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- hdl/bblc_scan.sv -----
`default_nettype none
module bblc_scan import bblc_pkg::*; #(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF,
    localparam int IW   = $clog2(ENTRIES),
    localparam int RW   = IW,
    localparam int BW   = $clog2(ENTRIES * 65535 + 1),
    localparam int C_LO = RW,
    localparam int B_LO = RW + 2,
    localparam int H_LO = RW + 18,
    localparam int K_LO = RW + 18 + HANDLE_BITS,
    localparam int EW   = K_LO + 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_clr,
    input  wire logic                   i_pv,
    input  wire logic [IW-1:0]          i_pidx,
    input  wire logic                   i_pvalid,
    input  wire logic [EW-1:0]          i_rdata,
    input  wire t_pass_ctl              i_ctl,
    input  wire logic [RW-1:0]          i_rank,
    input  wire logic [IW-1:0]          i_set_idx,
    input  wire logic [RW-1:0]          i_target,
    output logic                        o_wen,
    output logic      [EW-1:0]          o_wdata,
    output logic                        o_hit_f,
    output logic      [IW-1:0]          o_hit_idx,
    output logic      [RW-1:0]          o_hit_rank,
    output logic      [15:0]            o_hit_bytes,
    output logic      [HANDLE_BITS-1:0] o_hit_handle,
    output logic      [1:0]             o_hit_cls,
    output logic                        o_old_f,
    output logic      [IW-1:0]          o_old_idx,
    output logic      [15:0]            o_old_bytes,
    output logic                        o_cls_f,
    output logic      [IW-1:0]          o_cls_idx,
    output logic      [RW-1:0]          o_cls_rank,
    output logic      [15:0]            o_cls_bytes,
    output logic                        o_inv_f,
    output logic      [IW-1:0]          o_inv_idx,
    output logic      [BW-1:0]          o_cls_sum
);

    logic [RW-1:0]          e_rank;
    logic [1:0]             e_cls;
    logic [15:0]            e_bytes;
    logic [HANDLE_BITS-1:0] e_handle;
    logic [63:0]            e_key;
    logic [RW-1:0]          adj_rank;
    logic                   is_set;

    assign e_rank   = i_rdata[RW-1:0];
    assign e_cls    = i_rdata[C_LO +: 2];
    assign e_bytes  = i_rdata[B_LO +: 16];
    assign e_handle = i_rdata[H_LO +: HANDLE_BITS];
    assign e_key    = i_rdata[K_LO +: 64];

    always_comb begin
        adj_rank = e_rank;
        case (i_ctl.adj)
            ADJ_DEC_ABOVE: if (e_rank > i_rank) adj_rank = e_rank - RW'(1);
            ADJ_INC_BELOW: if (e_rank < i_rank) adj_rank = e_rank + RW'(1);
            ADJ_INC_ALL:   adj_rank = e_rank + RW'(1);
            default:       adj_rank = e_rank;
        endcase
    end

    assign is_set  = i_ctl.set_en && (i_pidx == i_set_idx);
    assign o_wen   = i_pv && (is_set || (i_pvalid && (adj_rank != e_rank)));
    assign o_wdata = is_set
        ? {i_ctl.key, HANDLE_BITS'(i_ctl.handle), i_ctl.size, i_ctl.src, RW'(0)}
        : {e_key, e_handle, e_bytes, e_cls, adj_rank};

    // Ranks seen by the oldest-entry and class finds are the adjusted ones, so
    // the oldest entry after a drop is found in the same pass that closes the gap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_hit_f <= 1'b0;
            o_old_f <= 1'b0;
            o_cls_f <= 1'b0;
            o_inv_f <= 1'b0;
        end else if (i_clr) begin
            o_hit_f   <= 1'b0;
            o_old_f   <= 1'b0;
            o_cls_f   <= 1'b0;
            o_inv_f   <= 1'b0;
            o_cls_sum <= '0;
        end else if (i_pv) begin
            if (i_pvalid && (e_key == i_ctl.key) && !o_hit_f) begin
                o_hit_f      <= 1'b1;
                o_hit_idx    <= i_pidx;
                o_hit_rank   <= e_rank;
                o_hit_bytes  <= e_bytes;
                o_hit_handle <= e_handle;
                o_hit_cls    <= e_cls;
            end
            if (i_pvalid && (adj_rank == i_target)) begin
                o_old_f     <= 1'b1;
                o_old_idx   <= i_pidx;
                o_old_bytes <= e_bytes;
            end
            if (i_pvalid && (e_cls == i_ctl.src)) begin
                o_cls_sum <= o_cls_sum + BW'(e_bytes);
                if (!o_cls_f) begin
                    o_cls_f     <= 1'b1;
                    o_cls_idx   <= i_pidx;
                    o_cls_rank  <= adj_rank;
                    o_cls_bytes <= e_bytes;
                end
            end
            if (!i_pvalid && !o_inv_f) begin
                o_inv_f   <= 1'b1;
                o_inv_idx <= i_pidx;
            end
        end
    end

endmodule
`default_nettype wire

// ----- hdl/byte_budget_lru_cache_core.sv -----
// Channel   Signals                                   Direction
// request   i_in_valid / o_in_ready / i_in_word       in
// result    o_out_valid / i_out_ready / o_out_word    out
// budget    i_cfg_we / i_cfg_data                     in, write only
//
// One word is handled at a time. Every request makes one pass through the
// entry RAM (one entry per cycle through the scan unit), and each rank
// update, eviction or class drop adds one more such pass.
// Reset is synchronous; all entries read as empty after reset, no sweep.
// A new request is taken while a result still waits on a stalled output.
`default_nettype none
module byte_budget_lru_cache_core import bblc_pkg::*; #(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_word          i_in_word,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_word              o_out_word,
    input  wire logic              i_cfg_we,
    input  wire logic [MAXB_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(ENTRIES);
    localparam int RW = IW;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int BW = $clog2(ENTRIES * 65535 + 1);
    localparam int EW = 64 + HANDLE_BITS + 16 + 2 + RW;
    localparam int SW = ((BW > MAXB_W) ? BW : MAXB_W) + 1;
    localparam int LW = (CW > 7) ? CW : 7;

    t_state              r_state;
    t_stage              r_stage;
    t_in_word            r_req;
    t_pass_ctl           r_ctl;
    logic [IW-1:0]       r_idx;
    logic [IW-1:0]       r_pidx;
    logic                r_pv;
    logic [ENTRIES-1:0]  r_valid;
    logic [BW-1:0]       r_bytes;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_evicted;
    logic [31:0]         r_hits;
    logic [31:0]         r_misses;
    logic [31:0]         r_evs;
    logic [MAXB_W-1:0]   r_max;
    logic [RW-1:0]       r_rank;
    logic [IW-1:0]       r_set_idx;
    logic                r_found;
    logic [31:0]         r_oh;
    logic [1:0]          r_os;
    logic                r_ovalid;
    t_out_word           r_out;

    logic                   w_clr;
    logic                   w_wen;
    logic [EW-1:0]          w_wdata;
    logic [EW-1:0]          w_rdata;
    logic [RW-1:0]          w_target;
    logic                   hit_f, old_f, cls_f, inv_f;
    logic [IW-1:0]          hit_idx, old_idx, cls_idx, inv_idx;
    logic [RW-1:0]          hit_rank, cls_rank;
    logic [15:0]            hit_bytes, old_bytes, cls_bytes;
    logic [HANDLE_BITS-1:0] hit_handle;
    logic [1:0]             hit_cls;
    logic [BW-1:0]          cls_sum;
    logic                   w_need_put;
    logic                   w_need_trim;
    logic                   w_evict;
    logic                   w_to_emit;
    logic                   w_set_en;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;
    assign w_target    = RW'(r_count - CW'(1));

    assign w_need_put = (r_count != '0) &&
        ((SW'(r_bytes) + SW'(r_req.value_size) > SW'(r_max)) ||
         (r_count >= CW'(ENTRIES)));
    assign w_need_trim = (r_count != '0) &&
        ((SW'(r_bytes) > SW'(r_max)) || (LW'(r_count) > LW'(r_req.entry_limit)));
    // A put that hits only rewrites its entry, so it never evicts.
    assign w_evict = old_f &&
        (((r_req.req_type == REQ_PUT) && !hit_f && w_need_put) ||
         ((r_req.req_type == REQ_TRIM) && w_need_trim));

    // The decision step goes on to the result once no further pass is needed.
    always_comb begin
        w_to_emit = 1'b0;
        if (r_stage == STG_FINAL) begin
            w_to_emit = 1'b1;
        end else if (!w_evict) begin
            case (r_req.req_type)
                REQ_PUT:             w_to_emit = 1'b0;
                REQ_GET, REQ_REMOVE: w_to_emit = !hit_f;
                REQ_CLR_SRC:         w_to_emit = !cls_f;
                default:             w_to_emit = 1'b1;
            endcase
        end
    end

    assign w_set_en = (r_stage != STG_FINAL) && !w_evict &&
        ((r_req.req_type == REQ_PUT) || ((r_req.req_type == REQ_GET) && hit_f));

    // A pass starts on accepting a word, or from the decision step unless it
    // goes on to the result.
    always_comb begin
        w_clr = 1'b0;
        if ((r_state == S_IDLE) && i_in_valid) begin
            w_clr = 1'b1;
        end else if ((r_state == S_DECIDE) && !w_to_emit) begin
            w_clr = 1'b1;
        end
    end

    bblc_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_wen),
        .i_waddr (r_pidx),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    bblc_scan #(
        .ENTRIES     (ENTRIES),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clr        (w_clr),
        .i_pv         (r_pv),
        .i_pidx       (r_pidx),
        .i_pvalid     (r_valid[r_pidx]),
        .i_rdata      (w_rdata),
        .i_ctl        (r_ctl),
        .i_rank       (r_rank),
        .i_set_idx    (r_set_idx),
        .i_target     (w_target),
        .o_wen        (w_wen),
        .o_wdata      (w_wdata),
        .o_hit_f      (hit_f),
        .o_hit_idx    (hit_idx),
        .o_hit_rank   (hit_rank),
        .o_hit_bytes  (hit_bytes),
        .o_hit_handle (hit_handle),
        .o_hit_cls    (hit_cls),
        .o_old_f      (old_f),
        .o_old_idx    (old_idx),
        .o_old_bytes  (old_bytes),
        .o_cls_f      (cls_f),
        .o_cls_idx    (cls_idx),
        .o_cls_rank   (cls_rank),
        .o_cls_bytes  (cls_bytes),
        .o_inv_f      (inv_f),
        .o_inv_idx    (inv_idx),
        .o_cls_sum    (cls_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pv     <= 1'b0;
            r_valid  <= '0;
            r_bytes  <= '0;
            r_count  <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_evs    <= '0;
            r_max    <= MAX_BYTES_RST;
            r_ovalid <= 1'b0;
        end else begin
            r_pv <= (r_state == S_SCAN);
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
            if ((r_state == S_EMIT) && (!r_ovalid || i_out_ready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req          <= i_in_word;
                        r_ctl.adj      <= ADJ_NONE;
                        r_ctl.set_en   <= 1'b0;
                        r_ctl.key      <= i_in_word.key;
                        r_ctl.handle   <= i_in_word.value_handle;
                        r_ctl.size     <= i_in_word.value_size;
                        r_ctl.src      <= i_in_word.source_code;
                        r_stage        <= STG_A;
                        r_idx          <= '0;
                        r_evicted      <= '0;
                        r_state        <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pidx <= r_idx;
                    r_idx  <= r_idx + IW'(1);
                    if (r_idx == IW'(ENTRIES - 1)) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_state      <= w_to_emit ? S_EMIT : S_SCAN;
                    r_idx        <= '0;
                    r_ctl.set_en <= w_set_en;
                    if (r_stage == STG_A) begin
                        r_found <= hit_f && ((r_req.req_type == REQ_GET) ||
                                             (r_req.req_type == REQ_REMOVE) ||
                                             (r_req.req_type == REQ_EXISTS));
                        r_oh <= (hit_f && (r_req.req_type == REQ_GET))
                                ? 32'(hit_handle) : '0;
                        r_os <= (hit_f && (r_req.req_type == REQ_GET)) ? hit_cls : '0;
                    end
                    if (r_stage != STG_FINAL) begin
                        if (w_evict) begin
                            // Drop the least recent entry, then close its rank gap.
                            r_valid[old_idx] <= 1'b0;
                            r_count          <= r_count - CW'(1);
                            r_bytes          <= r_bytes - BW'(old_bytes);
                            r_evs            <= r_evs + 32'd1;
                            r_evicted        <= r_evicted + CW'(1);
                            r_ctl.adj        <= ADJ_DEC_ABOVE;
                            r_rank           <= w_target;
                            r_stage          <= STG_DROP;
                        end else begin
                            case (r_req.req_type)
                                REQ_PUT: begin
                                    r_stage <= STG_FINAL;
                                    if ((r_stage == STG_A) && hit_f) begin
                                        r_bytes   <= r_bytes - BW'(hit_bytes)
                                                     + BW'(r_req.value_size);
                                        r_ctl.adj <= ADJ_INC_BELOW;
                                        r_rank    <= hit_rank;
                                        r_set_idx <= hit_idx;
                                    end else begin
                                        r_ctl.adj        <= ADJ_INC_ALL;
                                        r_set_idx        <= inv_idx;
                                        r_valid[inv_idx] <= 1'b1;
                                        r_count          <= r_count + CW'(1);
                                        r_bytes          <= r_bytes + BW'(r_req.value_size);
                                    end
                                end
                                REQ_GET: begin
                                    if (hit_f) begin
                                        r_hits       <= r_hits + 32'd1;
                                        r_ctl.adj    <= ADJ_INC_BELOW;
                                        r_ctl.handle <= 32'(hit_handle);
                                        r_ctl.size   <= hit_bytes;
                                        r_ctl.src    <= hit_cls;
                                        r_rank       <= hit_rank;
                                        r_set_idx    <= hit_idx;
                                        r_stage      <= STG_FINAL;
                                    end else begin
                                        r_misses <= r_misses + 32'd1;
                                    end
                                end
                                REQ_REMOVE: begin
                                    if (hit_f) begin
                                        r_valid[hit_idx] <= 1'b0;
                                        r_count          <= r_count - CW'(1);
                                        r_bytes          <= r_bytes - BW'(hit_bytes);
                                        r_ctl.adj        <= ADJ_DEC_ABOVE;
                                        r_rank           <= hit_rank;
                                        r_stage          <= STG_FINAL;
                                    end
                                end
                                REQ_CLR_ALL: begin
                                    r_valid   <= '0;
                                    r_evicted <= r_count;
                                    r_count   <= '0;
                                    r_bytes   <= '0;
                                end
                                REQ_CLR_SRC: begin
                                    if (cls_f) begin
                                        r_valid[cls_idx] <= 1'b0;
                                        r_count          <= r_count - CW'(1);
                                        r_bytes          <= r_bytes - BW'(cls_bytes);
                                        r_evicted        <= r_evicted + CW'(1);
                                        r_ctl.adj        <= ADJ_DEC_ABOVE;
                                        r_rank           <= cls_rank;
                                        r_stage          <= STG_DROP;
                                    end
                                end
                                default: begin
                                    // Exists, trim and size of source end here.
                                end
                            endcase
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_out.found            <= r_found;
                        r_out.out_value_handle <= r_oh;
                        r_out.out_source       <= r_os;
                        r_out.byte_total       <= (r_req.req_type == REQ_SIZE_SRC)
                                                  ? 22'(cls_sum) : 22'(r_bytes);
                        r_out.entry_count      <= 7'(r_count);
                        r_out.evicted_now      <= 7'(r_evicted);
                        r_out.hit_count        <= r_hits;
                        r_out.miss_count       <= r_misses;
                        r_out.eviction_count   <= r_evs;
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- hdl/bblc_chk.sv -----
`default_nettype none
module bblc_chk import bblc_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_word o_out_word
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word dropped or changed while stalled");

    // The block comes out of reset empty and ready.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("not idle after reset");

    // Only one request is in work at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word taken while busy");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.entry_count <= ENTRIES) &&
                        (o_out_word.evicted_now <= ENTRIES))
        else $error("entry or eviction count beyond table size");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.found |->
            (o_out_word.out_value_handle == '0) && (o_out_word.out_source == '0))
        else $error("handle or source shown without a hit");

endmodule

bind byte_budget_lru_cache_core bblc_chk #(
    .ENTRIES (ENTRIES)
) u_bblc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
`default_nettype wire
